/* sv/scs_pkg.sv */
`default_nettype none

package scs_pkg;

  typedef logic [7:0] byte_t;

  // Special characters seen by the scanner
  localparam byte_t CH_NEWLINE   = 8'h0A;
  localparam byte_t CH_BACKSLASH = 8'h5C;
  localparam byte_t CH_DQUOTE    = 8'h22;
  localparam byte_t CH_SQUOTE    = 8'h27;

  // Lookahead window depth in bytes
  localparam int unsigned WIN_BYTES = 3;

  // Delimiter register reset values: "//", "/*" and "*/"
  localparam logic [23:0] LINE_DELIM_RST  = 24'h00_2F2F;
  localparam logic [23:0] BLOCK_OPEN_RST  = 24'h00_2A2F;
  localparam logic [23:0] BLOCK_CLOSE_RST = 24'h00_2F2A;
  localparam logic [1:0]  DELIM_LEN_RST   = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LINE_DELIM      = 3'd0,
    REG_LINE_DELIM_LEN  = 3'd1,
    REG_BLOCK_OPEN      = 3'd2,
    REG_BLOCK_OPEN_LEN  = 3'd3,
    REG_BLOCK_CLOSE     = 3'd4,
    REG_BLOCK_CLOSE_LEN = 3'd5
  } cfg_reg_t;

  // Scanner context carried from byte to byte
  typedef struct packed {
    logic       in_line;
    logic       in_block;
    logic       in_char;
    logic       in_string;
    logic       esc_pending;
    logic [1:0] skip_cnt;
  } scan_state_t;

  // True if len is nonzero, no more than avail, and the first len bytes of the window equal the delimiter
  function automatic logic delim_match(logic [23:0] win, logic [23:0] delim,
                                       logic [1:0] len, logic [1:0] avail);
    logic ok;
    ok = (len != 2'd0) && (len <= avail);
    for (int k = 0; k < WIN_BYTES; k++) begin
      if ((k < int'(len)) && (win[8*k +: 8] != delim[8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* sv/scs_in_if.sv */
`default_nettype none

interface scs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

/* sv/scs_out_if.sv */
`default_nettype none

interface scs_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       out_final;

  modport source (output valid, output has_byte, output out_byte, output out_final,
                  input ready);
  modport sink   (input valid, input has_byte, input out_byte, input out_final,
                  output ready);
endinterface

`default_nettype wire

/* sv/source_comment_stripper_top.sv */
// Channel   Direction  Word / fields
// in_s      sink       in_byte[7:0], in_last
// out_m     source     has_byte, out_byte[7:0], out_final
// cfg_*     write      cfg_we, cfg_index[2:0], cfg_data[23:0]
//
// A kept byte that is not the last one leaves two input words late, from the
// output register.
// A last byte is taken into the window, then the window (1 to 3 bytes)
// drains one byte a cycle while the output register is free or being taken,
// and then the closing word is sent with out_final set.
// Reset is synchronous on rst_n and returns the control and configuration
// registers to their reset values; the window and output data are not reset.
// in_s.ready follows out_m.ready while the output register is full, and is
// low while the window drains.
`default_nettype none

module source_comment_stripper_top
  import scs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  scs_in_if.sink           in_s,
  scs_out_if.source        out_m,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  // Configuration registers
  logic [23:0] line_delim_r, block_open_r, block_close_r;
  logic [1:0]  line_len_r, bopen_len_r, bclose_len_r;

  // Scanner state
  scan_state_t st_r, st_nxt, st_step;
  logic [23:0] win_r, win_nxt, win_ins, step_win, win_shift;
  logic [1:0]  fill_r, fill_nxt, ins_idx, fill_ins, step_avail;
  logic        flush_r, flush_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  byte_t       pend_byte_r, pend_byte_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_has_r, out_has_nxt;
  byte_t       out_byte_r, out_byte_nxt;
  logic        out_final_r, out_final_nxt;

  logic        advance, in_acc;
  logic        kept;
  byte_t       head;
  logic        open_ctx;
  logic        m_close, m_line, m_open;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_delim_r  <= LINE_DELIM_RST;
      line_len_r    <= DELIM_LEN_RST;
      block_open_r  <= BLOCK_OPEN_RST;
      bopen_len_r   <= DELIM_LEN_RST;
      block_close_r <= BLOCK_CLOSE_RST;
      bclose_len_r  <= DELIM_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_DELIM:      line_delim_r  <= cfg_data;
        REG_LINE_DELIM_LEN:  line_len_r    <= cfg_data[1:0];
        REG_BLOCK_OPEN:      block_open_r  <= cfg_data;
        REG_BLOCK_OPEN_LEN:  bopen_len_r   <= cfg_data[1:0];
        REG_BLOCK_CLOSE:     block_close_r <= cfg_data;
        REG_BLOCK_CLOSE_LEN: bclose_len_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance whenever the output register is free or being taken
  assign advance     = !out_valid_r || out_m.ready;
  assign in_s.ready  = !flush_r && advance;
  assign in_acc      = in_s.valid && in_s.ready;

  // Place the incoming byte behind the bytes already held
  always_comb begin
    ins_idx  = (fill_r == 2'd3) ? 2'd2 : fill_r;
    fill_ins = ins_idx + 2'd1;
    win_ins  = win_r;
    win_ins[8*ins_idx +: 8] = in_s.in_byte;
  end

  // Select the window that the head decision looks at
  always_comb begin
    if (flush_r) begin
      step_win   = win_r;
      step_avail = fill_r;
    end else begin
      step_win   = win_ins;
      step_avail = 2'd3;
    end
    win_shift = {8'h00, step_win[23:8]};
  end

  // Decide on the head byte of the window
  always_comb begin
    head     = step_win[7:0];
    st_step  = st_r;
    kept     = 1'b0;
    open_ctx = !st_r.in_string && !st_r.in_char && !st_r.in_line &&
               !st_r.in_block && !st_r.esc_pending;
    m_close  = delim_match(step_win, block_close_r, bclose_len_r, step_avail);
    m_line   = delim_match(step_win, line_delim_r, line_len_r, step_avail);
    m_open   = delim_match(step_win, block_open_r, bopen_len_r, step_avail);
    if (st_r.skip_cnt != 2'd0) begin
      // drop the rest of a delimiter
      st_step.skip_cnt = st_r.skip_cnt - 2'd1;
    end else if (st_r.in_line && head == CH_NEWLINE) begin
      st_step.in_line = 1'b0;
      kept            = 1'b1;
    end else if (st_r.in_block && m_close) begin
      st_step.in_block = 1'b0;
      st_step.skip_cnt = bclose_len_r - 2'd1;
    end else if (open_ctx && m_line) begin
      st_step.in_line  = 1'b1;
      st_step.skip_cnt = line_len_r - 2'd1;
    end else if (open_ctx && m_open) begin
      st_step.in_block = 1'b1;
      st_step.skip_cnt = bopen_len_r - 2'd1;
    end else begin
      // track literals and escapes
      if (st_r.esc_pending) begin
        st_step.esc_pending = 1'b0;
      end else if (head == CH_BACKSLASH && (st_r.in_string || st_r.in_char)) begin
        st_step.esc_pending = 1'b1;
      end else if (head == CH_DQUOTE && !st_r.in_char && !st_r.in_line &&
                   !st_r.in_block) begin
        st_step.in_string = !st_r.in_string;
      end else if (head == CH_SQUOTE && !st_r.in_string && !st_r.in_line &&
                   !st_r.in_block) begin
        st_step.in_char = !st_r.in_char;
      end
      kept = !st_r.in_line && !st_r.in_block;
    end
  end

  // Next state: accept, step the window, drain and close a text
  always_comb begin
    st_nxt        = st_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    flush_nxt     = flush_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    out_has_nxt   = out_has_r;
    out_byte_nxt  = out_byte_r;
    out_final_nxt = out_final_r;
    if (advance) begin
      if (!flush_r) begin
        if (in_acc) begin
          if (in_s.in_last) begin
            // hold the last byte and start draining
            win_nxt      = win_ins;
            fill_nxt     = fill_ins;
            flush_nxt    = 1'b1;
            pend_vld_nxt = 1'b0;
          end else if (fill_ins == 2'd3) begin
            st_nxt   = st_step;
            win_nxt  = win_shift;
            fill_nxt = 2'd2;
            if (kept) begin
              out_valid_nxt = 1'b1;
              out_has_nxt   = 1'b1;
              out_byte_nxt  = head;
              out_final_nxt = 1'b0;
            end
          end else begin
            win_nxt  = win_ins;
            fill_nxt = fill_ins;
          end
        end
      end else if (fill_r != 2'd0) begin
        // drain one byte; keep the newest kept byte back for the final flag
        st_nxt   = st_step;
        win_nxt  = win_shift;
        fill_nxt = fill_r - 2'd1;
        if (kept) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_has_nxt   = 1'b1;
            out_byte_nxt  = pend_byte_r;
            out_final_nxt = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_byte_nxt = head;
        end
      end else begin
        // send the closing word and clear the stream context
        out_valid_nxt = 1'b1;
        out_has_nxt   = pend_vld_r;
        out_byte_nxt  = pend_vld_r ? pend_byte_r : 8'h00;
        out_final_nxt = 1'b1;
        st_nxt        = '0;
        win_nxt       = '0;
        fill_nxt      = 2'd0;
        flush_nxt     = 1'b0;
        pend_vld_nxt  = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      fill_r      <= 2'd0;
      flush_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      flush_r     <= flush_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win_r       <= win_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_has_r   <= out_has_nxt;
    out_byte_r  <= out_byte_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.has_byte  = out_has_r;
  assign out_m.out_byte  = out_byte_r;
  assign out_m.out_final = out_final_r;

  // A last word starts the drain
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_s.in_last) |=> flush_r)
    else $error("last word did not start the drain");

  // No word is taken while draining
  a_flush_block: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !in_s.ready)
    else $error("input ready while draining");

  // The drain ends with a final word in the output register
  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r && fill_r == 2'd0 && advance) |=> (!flush_r && out_valid_r && out_final_r))
    else $error("drain did not end with a final word");

  // Outside the drain the window never holds a full three bytes
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !flush_r |-> (fill_r != 2'd3))
    else $error("window over-filled outside the drain");

  // At most two delimiter bytes remain to drop
  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.skip_cnt != 2'd3)
    else $error("skip count out of range");

endmodule

`default_nettype wire
